// ===== design/ttga_pkg.sv =====
// Shared types, constants and cost functions for the truth-table gate ANF cost unit.
package ttga_pkg;

  localparam int unsigned TABLE_W = 64;
  localparam int unsigned PADDR_W = 5;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_TRUTH_TABLE    = 2'd0;
  localparam logic [1:0] REG_VAR_COUNT      = 2'd1;
  localparam logic [1:0] REG_EXTRA_CONTROLS = 2'd2;

  // Input op codes
  localparam logic OP_GATE   = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  typedef struct packed {
    logic       op;
    logic [2:0] target_line;
    logic [2:0] first_control;
    logic [2:0] second_control;
    logic       two_controls;
    logic [5:0] negations;
  } in_req_t;

  typedef struct packed {
    logic [63:0] result_table;
    logic [15:0] t_total;
    logic [15:0] n_total;
    logic        gate_overflow;
  } out_res_t;

  typedef struct packed {
    logic [63:0] truth_table;
    logic [2:0]  var_count;
    logic [4:0]  extra_controls;
  } cfg_regs_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NEG,
    ST_ANF,
    ST_SUM,
    ST_DONE
  } state_t;

  typedef enum logic {
    PM_SWAP,
    PM_BFLY
  } perm_mode_t;

  typedef struct packed {
    perm_mode_t  mode;
    logic [2:0]  shift_sel;
    logic [63:0] mask;
  } perm_req_t;

  typedef struct packed {
    logic        init;
    logic        add;
    logic [5:0]  mono;
    logic [4:0]  k;
    logic [15:0] t_init;
    logic [15:0] n_init;
  } cost_ctl_t;

  // Entries whose variable idx is 1; empty for an index past the last variable
  function automatic logic [63:0] vmask(input logic [2:0] idx);
    logic [63:0] m;
    unique case (idx)
      3'd0:    m = 64'haaaa_aaaa_aaaa_aaaa;
      3'd1:    m = 64'hcccc_cccc_cccc_cccc;
      3'd2:    m = 64'hf0f0_f0f0_f0f0_f0f0;
      3'd3:    m = 64'hff00_ff00_ff00_ff00;
      3'd4:    m = 64'hffff_0000_ffff_0000;
      3'd5:    m = 64'hffff_ffff_0000_0000;
      default: m = 64'h0;
    endcase
    return m;
  endfunction

  function automatic logic [2:0] popcount6(input logic [5:0] v);
    logic [2:0] c;
    c = 3'd0;
    for (int i = 0; i < 6; i++) begin
      c = c + 3'(v[i]);
    end
    return c;
  endfunction

  // T cost of a monomial with c controls
  function automatic logic [7:0] tcost(input logic [5:0] c);
    logic [7:0] v;
    if (c < 6'd2) begin
      v = 8'd0;
    end else if (c == 6'd2) begin
      v = 8'd1;
    end else begin
      v = {c, 2'b00} - 8'd8;
    end
    return v;
  endfunction

endpackage

// ===== design/ttga_cfg.sv =====
// APB-style configuration registers for the truth table, variable count and extra controls.
module ttga_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ttga_pkg::PADDR_W-1:0] paddr,
  input  logic [63:0]                  pwdata,
  output logic [63:0]                  prdata,
  output logic                         pready,
  output ttga_pkg::cfg_regs_t          regs
);
  import ttga_pkg::*;

  cfg_regs_t  regs_r;
  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[4:3];
  assign wr_en  = psel & penable & pwrite;
  assign regs   = regs_r;

  // Write the addressed register; drop writes past the list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.truth_table    <= 64'h0;
      regs_r.var_count      <= 3'd4;
      regs_r.extra_controls <= 5'd0;
    end else if (wr_en) begin
      unique case (idx)
        REG_TRUTH_TABLE:    regs_r.truth_table    <= pwdata;
        REG_VAR_COUNT:      regs_r.var_count      <= pwdata[2:0];
        REG_EXTRA_CONTROLS: regs_r.extra_controls <= pwdata[4:0];
        default:            ;
      endcase
    end
  end

  // Return the addressed register
  always_comb begin
    unique case (idx)
      REG_TRUTH_TABLE:    prdata = regs_r.truth_table;
      REG_VAR_COUNT:      prdata = {61'h0, regs_r.var_count};
      REG_EXTRA_CONTROLS: prdata = {59'h0, regs_r.extra_controls};
      default:            prdata = 64'h0;
    endcase
  end

endmodule

// ===== design/ttga_perm.sv =====
// Shared table permutation unit: masked delta swap or one ANF butterfly level.
module ttga_perm (
  input  logic [63:0]         table_in,
  input  ttga_pkg::perm_req_t req,
  output logic [63:0]         table_out
);
  import ttga_pkg::*;

  logic [6:0]  sh;
  logic [63:0] z;

  assign sh = 7'd1 << req.shift_sel;

  always_comb begin
    z = (table_in ^ (table_in >> sh)) & req.mask;
    unique case (req.mode)
      PM_SWAP: table_out = table_in ^ z ^ (z << sh);
      PM_BFLY: table_out = table_in ^ ((table_in << sh) & req.mask);
      default: table_out = table_in;
    endcase
  end

endmodule

// ===== design/ttga_cost.sv =====
// Accumulator for the T and N cost totals, one monomial per step.
module ttga_cost (
  input  logic                clk,
  input  ttga_pkg::cost_ctl_t ctl,
  output logic [15:0]         t_total,
  output logic [15:0]         n_total
);
  import ttga_pkg::*;

  logic [15:0] t_acc_r, t_acc_nxt;
  logic [15:0] n_acc_r, n_acc_nxt;
  logic [5:0]  c;
  logic [7:0]  tv;
  logic [7:0]  nv;

  assign c  = 6'(ctl.k) + 6'(popcount6(ctl.mono));
  assign tv = tcost(c);
  assign nv = (c <= 6'd2) ? 8'd1 : tv;

  // Seed with the frame cost, then add each present monomial
  always_comb begin
    t_acc_nxt = t_acc_r;
    n_acc_nxt = n_acc_r;
    if (ctl.init) begin
      t_acc_nxt = ctl.t_init;
      n_acc_nxt = ctl.n_init;
    end else if (ctl.add) begin
      t_acc_nxt = t_acc_r + 16'(tv);
      n_acc_nxt = n_acc_r + 16'(nv);
    end
  end

  always_ff @(posedge clk) begin
    t_acc_r <= t_acc_nxt;
    n_acc_r <= n_acc_nxt;
  end

  assign t_total = t_acc_r;
  assign n_total = n_acc_r;

endmodule

// ===== design/truth_table_gate_anf_cost_unit.sv =====
// Top level of the truth-table gate plan evaluator with ANF cost.
//
// A gate request (op 0) is taken while idle: the working table is permuted
// by a masked delta swap and the gate and Toffoli counts advance, so gates may
// arrive back to back. A finish request (op 1) runs n negation swap steps and
// n butterfly levels (n the effective variable count, 4 to MAX_VARS) through
// the one shared permutation unit, then the cost accumulator walks the ANF
// monomials one per cycle, and the result register is loaded. in_ready is low
// from the finish until that load. The result waits in an output register;
// gate requests of the next plan are taken while it waits, and a following
// finish holds only at its last step until the register is free.
// Configuration is an APB-style port with the truth table at byte address 0,
// var_count at 8 and extra_controls at 16; the truth table is taken at the
// first request of each plan.
module truth_table_gate_anf_cost_unit #(
  parameter int unsigned MAX_GATES = 32,
  parameter int unsigned MAX_VARS  = 6
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  ttga_pkg::in_req_t            in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output ttga_pkg::out_res_t           out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ttga_pkg::PADDR_W-1:0] paddr,
  input  logic [63:0]                  pwdata,
  output logic [63:0]                  prdata,
  output logic                         pready
);
  import ttga_pkg::*;

  localparam int unsigned GW = $clog2(MAX_GATES + 1);

  cfg_regs_t   cfg;
  state_t      state_r, state_nxt;
  logic [2:0]  step_r, step_nxt;
  logic [5:0]  mono_r, mono_nxt;
  logic [63:0] work_r, work_nxt;
  logic [63:0] anf_r, anf_nxt;
  logic [5:0]  pol_r, pol_nxt;
  logic [GW-1:0] gates_r, gates_nxt;
  logic [GW-1:0] toff_r, toff_nxt;
  logic        ovf_r, ovf_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_res_t    out_data_r, out_data_nxt;

  logic [2:0]  n_eff;
  logic [63:0] limit;
  logic [63:0] base;
  logic [63:0] gate_mask;
  logic [63:0] perm_in;
  logic [63:0] perm_out;
  perm_req_t   perm_req;
  cost_ctl_t   cost_ctl;
  logic [15:0] t_total;
  logic [15:0] n_total;
  logic        accept;
  logic        last_step;

  ttga_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .regs    (cfg)
  );

  ttga_perm u_perm (
    .table_in  (perm_in),
    .req       (perm_req),
    .table_out (perm_out)
  );

  ttga_cost u_cost (
    .clk     (clk),
    .ctl     (cost_ctl),
    .t_total (t_total),
    .n_total (n_total)
  );

  // Clamp the variable count and form the table limit
  always_comb begin
    if (cfg.var_count < 3'd4) begin
      n_eff = 3'd4;
    end else if (cfg.var_count > 3'(MAX_VARS)) begin
      n_eff = 3'(MAX_VARS);
    end else begin
      n_eff = cfg.var_count;
    end
    unique case (n_eff)
      3'd4:    limit = 64'h0000_0000_0000_ffff;
      3'd5:    limit = 64'h0000_0000_ffff_ffff;
      default: limit = 64'hffff_ffff_ffff_ffff;
    endcase
  end

  // Gate mask: all controls set, target bit clear; empty if the target or a used control is past the last line
  always_comb begin
    gate_mask = vmask(in_data.first_control);
    if (in_data.two_controls) begin
      gate_mask = gate_mask & vmask(in_data.second_control);
    end
    if (in_data.target_line < 3'd6) begin
      gate_mask = gate_mask & ~vmask(in_data.target_line);
    end else begin
      gate_mask = 64'h0;
    end
  end

  assign base      = (gates_r == '0) ? cfg.truth_table : work_r;
  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid & in_ready;
  assign last_step = (step_r == n_eff - 3'd1);

  // Sequencer: next state, datapath selects and cost control
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    mono_nxt      = mono_r;
    work_nxt      = work_r;
    anf_nxt       = anf_r;
    pol_nxt       = pol_r;
    gates_nxt     = gates_r;
    toff_nxt      = toff_r;
    ovf_nxt       = ovf_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r & ~out_ready;

    perm_in            = work_r;
    perm_req.mode      = PM_SWAP;
    perm_req.shift_sel = step_r;
    perm_req.mask      = 64'h0;

    cost_ctl.init   = 1'b0;
    cost_ctl.add    = 1'b0;
    cost_ctl.mono   = mono_r;
    cost_ctl.k      = cfg.extra_controls;
    cost_ctl.t_init = 16'(toff_r) << 1;
    cost_ctl.n_init = (16'(gates_r) << 1) + (16'(popcount6(in_data.negations)) << 1);

    unique case (state_r)
      ST_IDLE: begin
        perm_in            = base;
        perm_req.shift_sel = in_data.target_line;
        perm_req.mask      = gate_mask;
        if (accept) begin
          if (in_data.op == OP_GATE) begin
            if (gates_r >= GW'(MAX_GATES)) begin
              ovf_nxt = 1'b1;
            end else begin
              work_nxt  = perm_out;
              gates_nxt = gates_r + GW'(1);
              toff_nxt  = toff_r + GW'(in_data.two_controls);
            end
          end else begin
            work_nxt      = base;
            pol_nxt       = in_data.negations;
            step_nxt      = 3'd0;
            cost_ctl.init = 1'b1;
            state_nxt     = ST_NEG;
          end
        end
      end
      ST_NEG: begin
        perm_req.mask = pol_r[step_r] ? ~vmask(step_r) : 64'h0;
        if (last_step) begin
          work_nxt  = perm_out & limit;
          anf_nxt   = perm_out & limit;
          step_nxt  = 3'd0;
          state_nxt = ST_ANF;
        end else begin
          work_nxt = perm_out;
          step_nxt = step_r + 3'd1;
        end
      end
      ST_ANF: begin
        perm_in       = anf_r;
        perm_req.mode = PM_BFLY;
        perm_req.mask = vmask(step_r);
        if (last_step) begin
          anf_nxt   = perm_out & limit;
          mono_nxt  = 6'd0;
          state_nxt = ST_SUM;
        end else begin
          anf_nxt  = perm_out;
          step_nxt = step_r + 3'd1;
        end
      end
      ST_SUM: begin
        cost_ctl.add = anf_r[0];
        anf_nxt      = anf_r >> 1;
        mono_nxt     = mono_r + 6'd1;
        if (mono_r == 6'd63) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt.result_table  = work_r;
          out_data_nxt.t_total       = t_total;
          out_data_nxt.n_total       = n_total;
          out_data_nxt.gate_overflow = ovf_r;
          out_valid_nxt              = 1'b1;
          gates_nxt                  = '0;
          toff_nxt                   = '0;
          ovf_nxt                    = 1'b0;
          state_nxt                  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= 3'd0;
      mono_r      <= 6'd0;
      gates_r     <= '0;
      toff_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      mono_r      <= mono_nxt;
      gates_r     <= gates_nxt;
      toff_r      <= toff_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    work_r     <= work_nxt;
    anf_r      <= anf_nxt;
    pol_r      <= pol_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/ttga_checker.sv =====
// Port-level checker for the truth-table gate ANF cost unit, with its bind.
module ttga_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input ttga_pkg::in_req_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input ttga_pkg::out_res_t out_data
);
  import ttga_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // A finish request makes the block busy
  a_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.op == OP_FINISH |=> !in_ready)
    else $error("request taken right after a finish");

  // A gate request never brings a result
  a_gate_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.op == OP_GATE && !out_valid |=> !out_valid)
    else $error("result appeared after a gate request");

  // Each monomial and the frame cost at least as much N as T
  a_n_ge_t: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.n_total >= out_data.t_total)
    else $error("N total below T total");

endmodule

bind truth_table_gate_anf_cost_unit ttga_checker u_ttga_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the truth-table gate plan evaluator with ANF cost.
module testbench;
  import ttga_pkg::*;

  localparam int unsigned GATE_LIMIT = 32;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef enum logic {
    ROW_REQUEST,
    ROW_CONFIG
  } row_kind_t;

  typedef struct {
    row_kind_t   kind;
    in_req_t     req;
    logic [1:0]  reg_idx;
    logic [63:0] value;
    bit          typed;
    out_res_t    want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_req_t in_data;
  logic out_valid;
  logic out_ready;
  out_res_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic pready;

  // Register mirror and plan state of the predictor
  logic [63:0] func_table;
  logic [2:0] var_reg;
  logic [4:0] extra_reg;
  logic [63:0] plan_table;
  int unsigned plan_gates;
  int unsigned plan_toffolis;
  bit plan_overflow;

  out_res_t pending_costs[$];
  out_res_t oldest_cost;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 26;
  int unsigned recv_idle_pct = 55;
  stim_row_t directed[$];

  truth_table_gate_anf_cost_unit #(
    .MAX_GATES(GATE_LIMIT),
    .MAX_VARS (6)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Entries of the table whose index has bit b set
  function automatic logic [63:0] line_mask(input int unsigned b);
    logic [63:0] m;
    for (int x = 0; x < 64; x++) begin
      m[x] = (b < 6) ? x[b] : 1'b0;
    end
    return m;
  endfunction

  function automatic int unsigned monomial_tcost(input int unsigned c);
    return (c < 2) ? 0 : ((c == 2) ? 1 : 4 * c - 8);
  endfunction

  function automatic void clear_plan();
    plan_table = func_table;
    plan_gates = 0;
    plan_toffolis = 0;
    plan_overflow = 1'b0;
  endfunction

  // Apply one CNOT or Toffoli to the working table as a masked delta swap
  function automatic void gate_permute(input in_req_t r);
    logic [63:0] sel;
    logic [63:0] t;
    logic [63:0] z;
    int unsigned sh;
    if (plan_gates >= GATE_LIMIT) begin
      plan_overflow = 1'b1;
      return;
    end
    if (plan_gates == 0) plan_table = func_table;
    sel = line_mask(r.first_control);
    if (r.two_controls) sel &= line_mask(r.second_control);
    if (r.target_line < 6) begin
      sh = 1 << r.target_line;
      t = plan_table;
      z = (t ^ (t >> sh)) & sel & ~line_mask(r.target_line);
      plan_table = t ^ z ^ (z << sh);
    end
    plan_gates++;
    if (r.two_controls) plan_toffolis++;
  endfunction

  // Negate inputs, take the ANF and sum monomial costs; start a fresh plan
  function automatic out_res_t plan_cost(input logic [5:0] neg);
    out_res_t res;
    int unsigned n;
    int unsigned c;
    int unsigned v;
    int unsigned tsum;
    int unsigned nsum;
    logic [63:0] t;
    logic [63:0] anf;
    logic [63:0] keep;
    n = (var_reg < 4) ? 4 : ((var_reg > 6) ? 6 : var_reg);
    t = (plan_gates == 0) ? func_table : plan_table;
    tsum = 2 * plan_toffolis;
    nsum = 2 * plan_gates + 2 * $countones(neg);
    for (int b = 0; b < n; b++) begin
      if (neg[b]) begin
        t = ((t & ~line_mask(b)) << (1 << b)) | ((t & line_mask(b)) >> (1 << b));
      end
    end
    keep = (n >= 6) ? '1 : ((64'd1 << (1 << n)) - 64'd1);
    t &= keep;
    anf = t;
    for (int b = 0; b < n; b++) begin
      anf ^= (anf << (1 << b)) & line_mask(b);
    end
    anf &= keep;
    for (int m = 0; m < 64; m++) begin
      if (anf[m]) begin
        c = extra_reg + $countones(m);
        v = monomial_tcost(c);
        tsum += v;
        nsum += (c <= 2) ? 1 : v;
      end
    end
    res.result_table = t;
    res.t_total = 16'(tsum);
    res.n_total = 16'(nsum);
    res.gate_overflow = plan_overflow;
    clear_plan();
    return res;
  endfunction

  function automatic in_req_t mk_req(input logic op, input logic [2:0] tgt,
                                     input logic [2:0] c1, input logic [2:0] c2,
                                     input logic two, input logic [5:0] neg);
    in_req_t r;
    r.op = op;
    r.target_line = tgt;
    r.first_control = c1;
    r.second_control = c2;
    r.two_controls = two;
    r.negations = neg;
    return r;
  endfunction

  function automatic out_res_t mk_res(input logic [63:0] tbl, input logic [15:0] t,
                                      input logic [15:0] n, input logic ovf);
    out_res_t r;
    r.result_table = tbl;
    r.t_total = t;
    r.n_total = n;
    r.gate_overflow = ovf;
    return r;
  endfunction

  function automatic stim_row_t req_row(input in_req_t r);
    stim_row_t row;
    row = '{kind: ROW_REQUEST, req: r, reg_idx: '0, value: '0, typed: 1'b0, want: '0};
    return row;
  endfunction

  function automatic stim_row_t typed_row(input in_req_t r, input out_res_t w);
    stim_row_t row;
    row = '{kind: ROW_REQUEST, req: r, reg_idx: '0, value: '0, typed: 1'b1, want: w};
    return row;
  endfunction

  function automatic stim_row_t cfg_row(input logic [1:0] idx, input logic [63:0] val);
    stim_row_t row;
    row = '{kind: ROW_CONFIG, req: '0, reg_idx: idx, value: val, typed: 1'b0, want: '0};
    return row;
  endfunction

  // Mostly valid line indexes, now and then an index past the last variable
  function automatic logic [2:0] pick_line();
    return ($urandom_range(0, 7) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
  endfunction

  function automatic in_req_t random_gate();
    return mk_req(OP_GATE, pick_line(), pick_line(), pick_line(),
                  1'($urandom_range(0, 1)), 6'($urandom));
  endfunction

  // Hold the request until it is taken, then log its prediction
  task automatic push_request(input in_req_t r, input bit typed, input out_res_t want);
    out_res_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (r.op == OP_FINISH) begin
      predicted = plan_cost(r.negations);
      pending_costs.insert(pending_costs.size(), typed ? want : predicted);
    end else begin
      gate_permute(r);
    end
  endtask

  // Drop valid and wait until every result is out and the block is quiet
  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_costs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(idx) << 3;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_TRUTH_TABLE:    func_table = val;
      REG_VAR_COUNT:      var_reg = val[2:0];
      REG_EXTRA_CONTROLS: extra_reg = val[4:0];
      default:            ;
    endcase
    @(posedge clk);
  endtask

  // Random plans, now and then long enough to run past the gate limit
  task automatic run_plans(input int unsigned quota);
    int unsigned sent;
    int unsigned gates;
    sent = 0;
    while (sent < quota) begin
      gates = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 10);
      repeat (gates) push_request(random_gate(), 1'b0, '0);
      push_request(mk_req(OP_FINISH, 3'($urandom), 3'($urandom), 3'($urandom),
                          1'($urandom), 6'($urandom)), 1'b0, '0);
      sent += gates + 1;
    end
  endtask

  // Check each result against the oldest prediction; stall the receiver at random
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_costs.size() == 0) begin
        $error("result with no finish request pending");
        fail_count++;
      end else begin
        oldest_cost = pending_costs.pop_front();
        if (out_data.result_table !== oldest_cost.result_table) begin
          $error("result_table expected %h got %h", oldest_cost.result_table,
                 out_data.result_table);
          fail_count++;
        end
        if (out_data.t_total !== oldest_cost.t_total) begin
          $error("t_total expected %0d got %0d", oldest_cost.t_total, out_data.t_total);
          fail_count++;
        end
        if (out_data.n_total !== oldest_cost.n_total) begin
          $error("n_total expected %0d got %0d", oldest_cost.n_total, out_data.n_total);
          fail_count++;
        end
        if (out_data.gate_overflow !== oldest_cost.gate_overflow) begin
          $error("gate_overflow expected %0b got %0b", oldest_cost.gate_overflow,
                 out_data.gate_overflow);
          fail_count++;
        end
      end
    end
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    logic [63:0] tbl;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    out_ready <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    func_table = '0;
    var_reg = 3'd4;
    extra_reg = 5'd0;
    clear_plan();

    directed = '{
      // reset settings: empty table, only the negation frame cost counts
      typed_row(mk_req(OP_FINISH, 3'd0, 3'd0, 3'd0, 1'b0, 6'h00),
                mk_res(64'h0, 16'd0, 16'd0, 1'b0)),
      typed_row(mk_req(OP_FINISH, 3'd0, 3'd0, 3'd0, 1'b0, 6'h3f),
                mk_res(64'h0, 16'd0, 16'd12, 1'b0)),
      // constant one: ANF holds only the empty monomial
      cfg_row(REG_TRUTH_TABLE, '1),
      cfg_row(REG_VAR_COUNT, 64'd6),
      typed_row(mk_req(OP_FINISH, 3'd0, 3'd0, 3'd0, 1'b0, 6'h00),
                mk_res('1, 16'd0, 16'd1, 1'b0)),
      cfg_row(REG_TRUTH_TABLE, 64'h6996_9669_a55a_3cc3),
      req_row(mk_req(OP_GATE, 3'd0, 3'd1, 3'd0, 1'b0, 6'h00)),
      req_row(mk_req(OP_GATE, 3'd5, 3'd0, 3'd4, 1'b1, 6'h3f)),
      // target past the last line, control past the last line, control on target
      req_row(mk_req(OP_GATE, 3'd7, 3'd2, 3'd0, 1'b0, 6'h00)),
      req_row(mk_req(OP_GATE, 3'd3, 3'd6, 3'd0, 1'b0, 6'h00)),
      req_row(mk_req(OP_GATE, 3'd2, 3'd2, 3'd0, 1'b0, 6'h00)),
      req_row(mk_req(OP_GATE, 3'd1, 3'd3, 3'd7, 1'b1, 6'h00)),
      req_row(mk_req(OP_FINISH, 3'd0, 3'd0, 3'd0, 1'b0, 6'h3f)),
      cfg_row(REG_EXTRA_CONTROLS, 64'd20),
      req_row(mk_req(OP_GATE, 3'd4, 3'd5, 3'd5, 1'b1, 6'h00)),
      req_row(mk_req(OP_FINISH, 3'd7, 3'd7, 3'd7, 1'b1, 6'h00)),
      // four variables: swaps beyond the table and negations above n
      cfg_row(REG_VAR_COUNT, 64'd4),
      req_row(mk_req(OP_GATE, 3'd5, 3'd0, 3'd0, 1'b0, 6'h00)),
      req_row(mk_req(OP_GATE, 3'd4, 3'd1, 3'd2, 1'b1, 6'h00)),
      req_row(mk_req(OP_FINISH, 3'd0, 3'd0, 3'd0, 1'b0, 6'h31)),
      cfg_row(REG_EXTRA_CONTROLS, 64'd31),
      req_row(mk_req(OP_FINISH, 3'd0, 3'd0, 3'd0, 1'b0, 6'h0a))
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CONFIG) begin
        settle_block();
        write_reg(directed[i].reg_idx, directed[i].value);
      end else begin
        push_request(directed[i].req, directed[i].typed, directed[i].want);
      end
    end

    // Three idling regimes, each over several register settings
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 26 : ((ph == 1) ? 55 : 0);
      recv_idle_pct = (ph == 0) ? 55 : ((ph == 1) ? 26 : 0);
      for (int s = 0; s < 4; s++) begin
        settle_block();
        case ($urandom_range(0, 7))
          0:       tbl = '0;
          1:       tbl = '1;
          default: tbl = {$urandom, $urandom};
        endcase
        write_reg(REG_TRUTH_TABLE, tbl);
        case (s)
          0: begin
            write_reg(REG_VAR_COUNT, 64'd4);
            write_reg(REG_EXTRA_CONTROLS, 64'd0);
          end
          1: begin
            write_reg(REG_VAR_COUNT, 64'd6);
            write_reg(REG_EXTRA_CONTROLS, 64'd20);
          end
          2: begin
            write_reg(REG_VAR_COUNT, 64'($urandom_range(0, 7)));
            write_reg(REG_EXTRA_CONTROLS, 64'($urandom_range(0, 31)));
          end
          default: begin
            write_reg(REG_VAR_COUNT, 64'd5);
            write_reg(REG_EXTRA_CONTROLS, 64'($urandom_range(0, 20)));
          end
        endcase
        run_plans(42);
      end
    end

    // Drain and let the last finish settle
    in_valid <= 1'b0;
    while (pending_costs.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (pending_costs.size() != 0) begin
      $error("%0d results never arrived", pending_costs.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/ttga_pkg.sv
design/ttga_cfg.sv
design/ttga_perm.sv
design/ttga_cost.sv
design/truth_table_gate_anf_cost_unit.sv
design/ttga_checker.sv
dv/testbench.sv
